### hdl/rrc_pkg.sv
// Shared types, constants and helpers for the running rank counter.
package rrc_pkg;

  localparam int unsigned VALUE_W = 16;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned EPOCH_W = 8;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Register index, taken from paddr[2].
  localparam logic REG_DIRECTION_MODE = 1'b0;

  // Direction mode codes.
  localparam logic MODE_AT_MOST  = 1'b0;
  localparam logic MODE_AT_LEAST = 1'b1;

  // One tree node: the count is only meaningful when its tag matches the current epoch.
  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [COUNT_W-1:0] count;
  } tree_word_t;

  function automatic logic [COUNT_W-1:0] sat_count(input logic [COUNT_W+1:0] sum);
    logic [COUNT_W-1:0] res;
    res = (sum > {2'b00, COUNT_MAX}) ? COUNT_MAX : sum[COUNT_W-1:0];
    return res;
  endfunction

endpackage

### hdl/rrc_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
module rrc_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

### hdl/running_rank_counter.sv
// Running rank counter: for each word it returns how many earlier words of the run lie at or
// below it (mode 0, from 1 up) or at or above it (mode 1), then adds the word to a segment
// tree of per-value counts kept in one RAM of 2*VALUE_LIMIT entries with two read ports. The
// range query climbs at most log2(2*VALUE_LIMIT) tree levels, one level per cycle, and the
// insertion then walks leaf to root one level per cycle. A run start only bumps the current
// epoch, which is held against the tag stored with each node; every 2^8 runs, and once after
// reset, the block instead sweeps the whole RAM, stalling its input.
module running_rank_counter
  import rrc_pkg::*;
#(
  parameter int unsigned VALUE_LIMIT = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [VALUE_W-1:0] sample_value_i,
  input  logic               first_of_run_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [COUNT_W-1:0] rank_count_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int unsigned DEPTH = 2 * VALUE_LIMIT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned PW    = AW + 1;
  localparam int unsigned CW    = (VALUE_W > PW) ? VALUE_W : PW;
  localparam int unsigned WW    = $bits(tree_word_t);

  localparam logic [CW-1:0] VAL_MAX   = CW'(VALUE_LIMIT - 1);
  localparam logic [PW-1:0] LEAF_BASE = PW'(VALUE_LIMIT);
  localparam logic [PW-1:0] TREE_END  = PW'(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [AW-1:0] ROOT      = AW'(1);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_CLEAR     = 3'd1;
  localparam logic [2:0] ST_QUERY     = 3'd2;
  localparam logic [2:0] ST_INS_LEAF  = 3'd3;
  localparam logic [2:0] ST_INS_FIRST = 3'd4;
  localparam logic [2:0] ST_INS_UP    = 3'd5;
  localparam logic [2:0] ST_FINISH    = 3'd6;

  logic [2:0]         state_q, state_d;
  logic               item_q, item_d;
  logic [EPOCH_W-1:0] epoch_q, epoch_d;
  logic               mode_q;
  logic [AW-1:0]      clr_q, clr_d;
  logic [PW-1:0]      l_q, l_d;
  logic [PW-1:0]      r_q, r_d;
  logic               pend_a_q, pend_a_d;
  logic               pend_b_q, pend_b_d;
  logic [COUNT_W-1:0] acc_q, acc_d;
  logic [AW-1:0]      pos_q, pos_d;
  logic [COUNT_W-1:0] cur_q, cur_d;
  logic               out_valid_q, out_valid_d;
  logic [COUNT_W-1:0] rank_q, rank_d;

  logic               accept;
  logic               cfg_write;
  logic [CW-1:0]      v_ext;
  logic [CW-1:0]      v_cl;
  logic [PW-1:0]      leaf_idx;
  logic [PW-1:0]      r_dec;
  logic [AW-1:0]      parent;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  tree_word_t         ram_wdata;
  logic [AW-1:0]      ram_raddr_a;
  logic [AW-1:0]      ram_raddr_b;
  tree_word_t         rd_a;
  tree_word_t         rd_b;
  logic [WW-1:0]      rd_a_raw;
  logic [WW-1:0]      rd_b_raw;
  logic [COUNT_W-1:0] cnt_a;
  logic [COUNT_W-1:0] cnt_b;
  logic [COUNT_W-1:0] leaf_new;
  logic [COUNT_W-1:0] up_sum;

  rrc_ram #(
    .WIDTH(WW),
    .DEPTH(DEPTH)
  ) u_tree_ram (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (ram_waddr),
    .wdata_i  (ram_wdata),
    .raddr_a_i(ram_raddr_a),
    .raddr_b_i(ram_raddr_b),
    .rdata_a_o(rd_a_raw),
    .rdata_b_o(rd_b_raw)
  );

  assign rd_a = rd_a_raw;
  assign rd_b = rd_b_raw;

  // A node written in an older run reads as zero.
  assign cnt_a = (rd_a.tag == epoch_q) ? rd_a.count : '0;
  assign cnt_b = (rd_b.tag == epoch_q) ? rd_b.count : '0;

  assign leaf_new = sat_count({2'b00, cnt_a} + (COUNT_W+2)'(1));
  assign up_sum   = sat_count({2'b00, cur_q} + {2'b00, cnt_a});

  assign in_stall_o   = (state_q != ST_IDLE);
  assign accept       = in_valid_i && !in_stall_o;
  assign out_valid_o  = out_valid_q;
  assign rank_count_o = rank_q;

  assign v_ext    = CW'(sample_value_i);
  assign v_cl     = (v_ext > VAL_MAX) ? VAL_MAX : v_ext;
  assign leaf_idx = LEAF_BASE + PW'(v_cl);
  assign r_dec    = r_q - PW'(1);
  assign parent   = pos_q >> 1;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[2] == REG_DIRECTION_MODE) ? PDATA_W'(mode_q) : '0;

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    epoch_d     = epoch_q;
    clr_d       = clr_q;
    l_d         = l_q;
    r_d         = r_q;
    pend_a_d    = 1'b0;
    pend_b_d    = 1'b0;
    pos_d       = pos_q;
    cur_d       = cur_q;
    rank_d      = rank_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_waddr   = pos_q;
    ram_wdata   = '0;
    ram_raddr_a = l_q[AW-1:0];
    ram_raddr_b = r_dec[AW-1:0];

    // Query reads land in the cycle after issue and are folded in here.
    acc_d = sat_count({2'b00, acc_q}
                      + (pend_a_q ? {2'b00, cnt_a} : '0)
                      + (pend_b_q ? {2'b00, cnt_b} : '0));

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          item_d = 1'b1;
          acc_d  = '0;
          pos_d  = leaf_idx[AW-1:0];
          unique case (mode_q)
            MODE_AT_MOST: begin
              l_d = LEAF_BASE + PW'(1);
              r_d = leaf_idx + PW'(1);
            end
            MODE_AT_LEAST: begin
              l_d = leaf_idx;
              r_d = TREE_END;
            end
            default: begin
              l_d = leaf_idx;
              r_d = TREE_END;
            end
          endcase
          if (first_of_run_i && (epoch_q == '1)) begin
            clr_d   = '0;
            state_d = ST_CLEAR;
          end else begin
            if (first_of_run_i) begin
              epoch_d = epoch_q + EPOCH_W'(1);
            end
            state_d = ST_QUERY;
          end
        end
      end
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == LAST_ADDR) begin
          epoch_d = '0;
          state_d = item_q ? ST_QUERY : ST_IDLE;
        end
      end
      ST_QUERY: begin
        if (l_q < r_q) begin
          pend_a_d = l_q[0];
          pend_b_d = r_q[0];
          l_d      = (l_q + PW'(l_q[0])) >> 1;
          r_d      = (r_q - PW'(r_q[0])) >> 1;
        end else begin
          state_d = ST_INS_LEAF;
        end
      end
      ST_INS_LEAF: begin
        ram_raddr_a = pos_q;
        state_d     = ST_INS_FIRST;
      end
      ST_INS_FIRST: begin
        ram_we      = 1'b1;
        ram_waddr   = pos_q;
        ram_wdata   = '{tag: epoch_q, count: leaf_new};
        cur_d       = leaf_new;
        ram_raddr_a = pos_q ^ ROOT;
        state_d     = ST_INS_UP;
      end
      ST_INS_UP: begin
        // The sibling arrives now; the node just written is the other child.
        ram_we      = 1'b1;
        ram_waddr   = parent;
        ram_wdata   = '{tag: epoch_q, count: up_sum};
        cur_d       = up_sum;
        pos_d       = parent;
        ram_raddr_a = parent ^ ROOT;
        if (parent == ROOT) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          rank_d      = acc_q;
          item_d      = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      item_q      <= 1'b0;
      epoch_q     <= '0;
      clr_q       <= '0;
      pend_a_q    <= 1'b0;
      pend_b_q    <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= MODE_AT_MOST;
    end else begin
      state_q     <= state_d;
      item_q      <= item_d;
      epoch_q     <= epoch_d;
      clr_q       <= clr_d;
      pend_a_q    <= pend_a_d;
      pend_b_q    <= pend_b_d;
      out_valid_q <= out_valid_d;
      if (cfg_write && (paddr[2] == REG_DIRECTION_MODE)) begin
        mode_q <= pwdata[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    l_q    <= l_d;
    r_q    <= r_d;
    acc_q  <= acc_d;
    pos_q  <= pos_d;
    cur_q  <= cur_d;
    rank_q <= rank_d;
  end

endmodule
